>>> rtl/att_pkg.sv
// att_pkg: shared types and fixed constants for the ack timeout tracker.
// No dependencies.
package att_pkg;

  localparam int PKT_W       = 16;
  localparam int CNT_W       = 16;
  localparam int OUT_SEQ_W   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    OUT_SENT      = 2'd0,
    OUT_ACKED     = 2'd1,
    OUT_TIMED_OUT = 2'd2,
    OUT_REFUSED   = 2'd3
  } outcome_t;

endpackage

>>> rtl/ack_timeout_tracker_core.sv
// ack_timeout_tracker_core: pending-ack table with per-slot timeout countdown.
// Depends on att_pkg.
//
// One item is taken at a time; in_ready is high only when the sequencer is
// idle. A send goes through S_SEND, an ack through S_ACK_RD and S_ACK_CHK
// when PENDING_DEPTH is a power of two, else first S_ACK_DIV (a reciprocal
// multiply gives the quotient) and S_ACK_REM (a multiply-subtract gives the
// slot); a tick scans the single slot memory one entry per cycle through its
// one read port. A result that out_ready holds back stalls any of them. A
// tick reports expiries in ascending slot order, at most sixteen per tick,
// the final one with out_last. No clearing pass is needed after reset.
module ack_timeout_tracker_core #(
  parameter int PENDING_DEPTH = 16,
  parameter int SEQ_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_ack_seq,
  input  logic [15:0] in_packet_id,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [15:0] out_seq_number,
  output logic [15:0] out_result_packet,
  output logic        out_last
);

  localparam int IDXW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam bit DEPTH_POW2 = (PENDING_DEPTH & (PENDING_DEPTH - 1)) == 0;
  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(PENDING_DEPTH - 1);
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
  localparam int RW = att_pkg::RES_CNT_W;
  // ceil(2^(SEQ_BITS+IDXW) / depth): exact quotient for every SEQ_BITS-bit ack
  localparam int RSH = SEQ_BITS + IDXW;
  localparam logic [SEQ_BITS:0] RECIP = (SEQ_BITS + 1)'(((64'd1 << RSH) +
                                        64'(PENDING_DEPTH) - 64'd1) / 64'(PENDING_DEPTH));
  localparam logic [SEQ_BITS-1:0] DEPTH_S = SEQ_BITS'(PENDING_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_ACK_DIV,
    S_ACK_REM,
    S_ACK_RD,
    S_ACK_CHK,
    S_TICK,
    S_TICK_END
  } state_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]          seq;
    logic [att_pkg::PKT_W-1:0]    pkt;
    logic [att_pkg::CNT_W-1:0]    cnt;
  } slot_t;

  // slot memory
  slot_t              mem [PENDING_DEPTH];
  slot_t              rd_data_r;
  logic [IDXW-1:0]    rd_addr;
  logic               mem_we;
  logic [IDXW-1:0]    mem_waddr;
  slot_t              mem_wdata;

  state_t                      state_r, state_nxt;
  logic [15:0]                 timeout_r, timeout_nxt;
  logic [SEQ_BITS-1:0]         next_seq_r, next_seq_nxt;
  logic [IDXW-1:0]             next_slot_r, next_slot_nxt;
  logic [PENDING_DEPTH-1:0]    slot_valid_r, slot_valid_nxt;
  logic [att_pkg::PKT_W-1:0]   pkt_r, pkt_nxt;
  logic [SEQ_BITS-1:0]         ack_val_r, ack_val_nxt;
  logic [IDXW-1:0]             ack_rem_r, ack_rem_nxt;
  logic [SEQ_BITS-1:0]         quo_r, quo_nxt;
  logic [IDXW-1:0]             scan_r, scan_nxt;
  logic [RW-1:0]               res_cnt_r, res_cnt_nxt;
  logic                        hold_v_r, hold_v_nxt;
  logic [SEQ_BITS-1:0]         hold_seq_r, hold_seq_nxt;
  logic [att_pkg::PKT_W-1:0]   hold_pkt_r, hold_pkt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  att_pkg::outcome_t           out_outcome_r, out_outcome_nxt;
  logic [15:0]                 out_seq_r, out_seq_nxt;
  logic [15:0]                 out_pkt_r, out_pkt_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        out_free;
  logic [SEQ_BITS-1:0]         ack_masked;
  logic [2*SEQ_BITS:0]         quo_prod;
  logic [SEQ_BITS-1:0]         rem_val;
  logic                        tick_expire;
  logic                        tick_stall;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign ack_masked = SEQ_BITS'(in_ack_seq);

  // slot of an ack for a depth that is not a power of two: quotient, then remainder
  assign quo_prod = (2*SEQ_BITS+1)'(ack_val_r) * (2*SEQ_BITS+1)'(RECIP);
  assign rem_val  = ack_val_r - quo_r * DEPTH_S;

  assign tick_expire = slot_valid_r[scan_r] && (rd_data_r.cnt <= 16'd1);
  assign tick_stall  = tick_expire && (res_cnt_r < RW'(att_pkg::MAX_RESULTS)) &&
                       hold_v_r && !out_free;

  always_comb begin
    case (state_r)
      S_TICK: begin
        if (tick_stall) begin
          rd_addr = scan_r;
        end else if (scan_r == LAST_SLOT) begin
          rd_addr = '0;
        end else begin
          rd_addr = scan_r + 1'b1;
        end
      end
      S_ACK_RD, S_ACK_CHK: rd_addr = ack_rem_r;
      default:             rd_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    timeout_nxt     = timeout_r;
    next_seq_nxt    = next_seq_r;
    next_slot_nxt   = next_slot_r;
    slot_valid_nxt  = slot_valid_r;
    pkt_nxt         = pkt_r;
    ack_val_nxt     = ack_val_r;
    ack_rem_nxt     = ack_rem_r;
    quo_nxt         = quo_r;
    scan_nxt        = scan_r;
    res_cnt_nxt     = res_cnt_r;
    hold_v_nxt      = hold_v_r;
    hold_seq_nxt    = hold_seq_r;
    hold_pkt_nxt    = hold_pkt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_outcome_nxt = out_outcome_r;
    out_seq_nxt     = out_seq_r;
    out_pkt_nxt     = out_pkt_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = next_slot_r;
    mem_wdata       = '{seq: next_seq_r, pkt: pkt_r, cnt: timeout_r};

    if (cfg_valid) begin
      timeout_nxt = cfg_timeout_ticks;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pkt_nxt     = in_packet_id;
          ack_val_nxt = ack_masked;
          case (att_pkg::op_t'(in_operation))
            att_pkg::OP_SEND: state_nxt = S_SEND;
            att_pkg::OP_ACK: begin
              if (DEPTH_POW2) begin
                ack_rem_nxt = IDXW'(ack_masked);
                state_nxt   = S_ACK_RD;
              end else begin
                state_nxt   = S_ACK_DIV;
              end
            end
            att_pkg::OP_TICK: begin
              scan_nxt    = '0;
              res_cnt_nxt = '0;
              hold_v_nxt  = 1'b0;
              state_nxt   = S_TICK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_seq_nxt   = 16'(next_seq_r);
          out_pkt_nxt   = pkt_r;
          out_last_nxt  = 1'b1;
          if (slot_valid_r[next_slot_r]) begin
            out_outcome_nxt = att_pkg::OUT_REFUSED;
          end else begin
            out_outcome_nxt             = att_pkg::OUT_SENT;
            mem_we                      = 1'b1;
            slot_valid_nxt[next_slot_r] = 1'b1;
            next_seq_nxt                = next_seq_r + 1'b1;
            // slot index follows the sequence, and restarts when it wraps
            if (next_seq_r == SEQ_MAX || next_slot_r == LAST_SLOT) begin
              next_slot_nxt = '0;
            end else begin
              next_slot_nxt = next_slot_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      S_ACK_DIV: begin
        quo_nxt   = SEQ_BITS'(quo_prod >> RSH);
        state_nxt = S_ACK_REM;
      end

      S_ACK_REM: begin
        ack_rem_nxt = IDXW'(rem_val);
        state_nxt   = S_ACK_RD;
      end

      S_ACK_RD: state_nxt = S_ACK_CHK;

      S_ACK_CHK: begin
        if (slot_valid_r[ack_rem_r] && rd_data_r.seq == ack_val_r) begin
          if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_outcome_nxt           = att_pkg::OUT_ACKED;
            out_seq_nxt               = 16'(ack_val_r);
            out_pkt_nxt               = rd_data_r.pkt;
            out_last_nxt              = 1'b1;
            slot_valid_nxt[ack_rem_r] = 1'b0;
            state_nxt                 = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_TICK: begin
        if (!tick_stall) begin
          mem_waddr = scan_r;
          mem_wdata = rd_data_r;
          if (slot_valid_r[scan_r]) begin
            if (!tick_expire) begin
              mem_we        = 1'b1;
              mem_wdata.cnt = rd_data_r.cnt - 1'b1;
            end else if (res_cnt_r < RW'(att_pkg::MAX_RESULTS)) begin
              // expiry goes to the hold stage; the one held before is not last
              if (hold_v_r) begin
                out_valid_nxt   = 1'b1;
                out_outcome_nxt = att_pkg::OUT_TIMED_OUT;
                out_seq_nxt     = 16'(hold_seq_r);
                out_pkt_nxt     = hold_pkt_r;
                out_last_nxt    = 1'b0;
              end
              hold_v_nxt             = 1'b1;
              hold_seq_nxt           = rd_data_r.seq;
              hold_pkt_nxt           = rd_data_r.pkt;
              res_cnt_nxt            = res_cnt_r + 1'b1;
              slot_valid_nxt[scan_r] = 1'b0;
            end else begin
              mem_we        = 1'b1;
              mem_wdata.cnt = '0;
            end
          end
          if (scan_r == LAST_SLOT) begin
            state_nxt = S_TICK_END;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_TICK_END: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = att_pkg::OUT_TIMED_OUT;
          out_seq_nxt     = 16'(hold_seq_r);
          out_pkt_nxt     = hold_pkt_r;
          out_last_nxt    = 1'b1;
          hold_v_nxt      = 1'b0;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= att_pkg::TIMEOUT_RESET;
      next_seq_r   <= '0;
      next_slot_r  <= '0;
      slot_valid_r <= '0;
      hold_v_r     <= 1'b0;
      res_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      timeout_r    <= timeout_nxt;
      next_seq_r   <= next_seq_nxt;
      next_slot_r  <= next_slot_nxt;
      slot_valid_r <= slot_valid_nxt;
      hold_v_r     <= hold_v_nxt;
      res_cnt_r    <= res_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pkt_r         <= pkt_nxt;
    ack_val_r     <= ack_val_nxt;
    ack_rem_r     <= ack_rem_nxt;
    quo_r         <= quo_nxt;
    scan_r        <= scan_nxt;
    hold_seq_r    <= hold_seq_nxt;
    hold_pkt_r    <= hold_pkt_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_seq_r     <= out_seq_nxt;
    out_pkt_r     <= out_pkt_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_outcome       = out_outcome_r;
  assign out_seq_number    = out_seq_r;
  assign out_result_packet = out_pkt_r;
  assign out_last          = out_last_r;

`ifndef ASSERT_OFF
  a_hold_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (state_r == S_TICK || state_r == S_TICK_END))
    else $error("held expiry outside a tick scan");

  a_res_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RW'(att_pkg::MAX_RESULTS))
    else $error("expiry count above limit");

  a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(next_slot_r) < PENDING_DEPTH)
    else $error("next slot index out of range");

  a_send_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND && out_free && !slot_valid_r[next_slot_r])
    |=> slot_valid_r[$past(next_slot_r)])
    else $error("accepted send left its slot empty");

  a_ack_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACK_RD) |-> (32'(ack_rem_r) < PENDING_DEPTH))
    else $error("ack slot remainder out of range");
`endif

endmodule

>>> tb/att_tracker_checker.sv
`timescale 1ns / 100ps
// att_tracker_checker: watches the config, input and result channels of the ack timeout
// tracker, keeps a shadow copy of its pending table and checks every result item.
// Depends on att_pkg.
module att_tracker_checker
  import att_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int SEQ_W = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_ack_seq,
  input  logic [15:0] in_packet_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_outcome,
  input  logic [15:0] out_seq_number,
  input  logic [15:0] out_result_packet,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    outcome_t             outcome;
    logic [OUT_SEQ_W-1:0] seq;
    logic [PKT_W-1:0]     pkt;
    logic                 last;
  } report_t;

  // shadow of the pending table
  logic [CNT_W-1:0] timeout_now;
  logic [SEQ_W-1:0] seq_next;
  logic             slot_live [DEPTH];
  logic [SEQ_W-1:0] slot_seq  [DEPTH];
  logic [PKT_W-1:0] slot_pkt  [DEPTH];
  logic [CNT_W-1:0] slot_left [DEPTH];

  report_t expected_reports [$];
  report_t want;
  int      errors = 0;

  function automatic report_t make_report(input outcome_t o, input logic [SEQ_W-1:0] s,
                                          input logic [PKT_W-1:0] p, input logic l);
    report_t rep;
    rep.outcome = o;
    rep.seq     = OUT_SEQ_W'(s);
    rep.pkt     = p;
    rep.last    = l;
    return rep;
  endfunction

  task automatic note_mismatch(input string detail);
    errors++;
    if (errors <= 10) begin
      $display("%0t mismatch: %s; got outcome=%0d seq=%h packet=%h last=%b", $time, detail,
               out_outcome, out_seq_number, out_result_packet, out_last);
    end
  endtask

  // Updates the shadow table for one accepted item and queues the reports it causes.
  task automatic track_item(input logic [1:0] op, input logic [15:0] ack,
                            input logic [15:0] pkt);
    int               slot;
    int               fired;
    logic [SEQ_W-1:0] ack_m;
    fired = 0;
    ack_m = SEQ_W'(ack);
    case (op)
      OP_SEND: begin
        slot = seq_next % DEPTH;
        if (slot_live[slot]) begin
          // slot still waiting: refused, sequence not consumed
          expected_reports.push_back(make_report(OUT_REFUSED, seq_next, pkt, 1'b1));
        end else begin
          slot_live[slot] = 1'b1;
          slot_seq[slot]  = seq_next;
          slot_pkt[slot]  = pkt;
          slot_left[slot] = timeout_now;
          expected_reports.push_back(make_report(OUT_SENT, seq_next, pkt, 1'b1));
          seq_next = seq_next + 1'b1;
        end
      end
      OP_ACK: begin
        slot = ack_m % DEPTH;
        if (slot_live[slot] && slot_seq[slot] == ack_m) begin
          slot_live[slot] = 1'b0;
          expected_reports.push_back(make_report(OUT_ACKED, ack_m, slot_pkt[slot], 1'b1));
        end
      end
      OP_TICK: begin
        for (int s = 0; s < DEPTH; s++) begin
          if (slot_live[s]) begin
            if (slot_left[s] > 1) begin
              slot_left[s]--;
            end else if (fired < MAX_RESULTS) begin
              slot_live[s] = 1'b0;
              expected_reports.push_back(make_report(OUT_TIMED_OUT, slot_seq[s], slot_pkt[s],
                                                     1'b0));
              fired++;
            end else begin
              slot_left[s] = '0;  // held over to a later tick
            end
          end
        end
        if (fired > 0) expected_reports[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_now = TIMEOUT_RESET;
      seq_next    = '0;
      for (int s = 0; s < DEPTH; s++) slot_live[s] = 1'b0;
      expected_reports.delete();
    end else begin
      // results here belong to items taken at earlier edges, so check before predicting
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          note_mismatch("no result was due");
        end else begin
          want = expected_reports.pop_front();
          if (out_outcome !== want.outcome || out_seq_number !== want.seq ||
              out_result_packet !== want.pkt || out_last !== want.last) begin
            note_mismatch($sformatf("expected outcome=%0d seq=%h packet=%h last=%b",
                                    want.outcome, want.seq, want.pkt, want.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) timeout_now = cfg_timeout_ticks;
      if (in_valid && in_ready) track_item(in_operation, in_ack_seq, in_packet_id);
    end
    mismatches  <= errors;
    outstanding <= expected_reports.size();
  end

endmodule

>>> tb/tb_ack_timeout_tracker_core.sv
`timescale 1ns / 100ps
// tb_ack_timeout_tracker_core: drives sends, acks and ticks into ack_timeout_tracker_core
// under several timeout settings and gives the verdict.
// Depends on att_pkg, ack_timeout_tracker_core and att_tracker_checker.
module tb_ack_timeout_tracker_core;
  import att_pkg::*;

  localparam int         SETTLE_CYCLES = 40;
  localparam int         PHASE_ITEMS   = 80;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_timeout_ticks = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_ack_seq = '0;
  logic [15:0] in_packet_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_outcome;
  logic [15:0] out_seq_number;
  logic [15:0] out_result_packet;
  logic        out_last;

  int          mismatches;
  int          outstanding;
  logic        quiet = 1'b0;
  int          rx_hold = 0;
  logic [15:0] live_seqs [$];
  logic [15:0] last_seq = '0;
  int          op_count [4] = '{0, 0, 0, 0};
  int          outcome_count [4] = '{0, 0, 0, 0};
  int          settings_used = 0;

  always #1 clk = ~clk;

  ack_timeout_tracker_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_timeout_ticks(cfg_timeout_ticks),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_ack_seq       (in_ack_seq),
    .in_packet_id     (in_packet_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_seq_number   (out_seq_number),
    .out_result_packet(out_result_packet),
    .out_last         (out_last)
  );

  att_tracker_checker tracker_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_timeout_ticks(cfg_timeout_ticks),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_ack_seq       (in_ack_seq),
    .in_packet_id     (in_packet_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_seq_number   (out_seq_number),
    .out_result_packet(out_result_packet),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_item(input logic [1:0] op, input logic [15:0] ack, input logic [15:0] pkt);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_ack_seq   <= ack;
    in_packet_id <= pkt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    op_count[op]++;
  endtask

  // wait until every predicted result is out, then give a silent item time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    cfg_valid         <= 1'b1;
    cfg_timeout_ticks <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result side back-pressure
  always @(posedge clk) begin : rx_side
    int span;
    span = (rx_hold > 0) ? 0 : idle_span();
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (span > 0) begin
      out_ready <= 1'b0;
      rx_hold   <= span - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // track which sequences are in flight so acks can aim at them
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      outcome_count[out_outcome]++;
      if (out_outcome == OUT_SENT) begin
        live_seqs.push_back(out_seq_number);
        last_seq = out_seq_number;
      end else if (out_outcome == OUT_ACKED || out_outcome == OUT_TIMED_OUT) begin
        for (int i = 0; i < live_seqs.size(); i++) begin
          if (live_seqs[i] == out_seq_number) begin
            live_seqs.delete(i);
            break;
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] phase_ticks [6];
    logic [15:0] drain [$];
    logic [15:0] ack;
    int          done;
    int          r;
    int          burst;
    bit          paused;
    phase_ticks    = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd7, 16'd1};
    phase_ticks[4] = 16'($urandom_range(3, 12));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset timeout
    put_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    put_item(OP_ACK, 16'h0000, 16'h1234);   // empty table
    put_item(OP_TICK, 16'h5A5A, 16'hA5A5);  // nothing pending
    put_item(OP_SEND, 16'hFFFF, 16'h0000);  // seq 0
    put_item(OP_SEND, 16'h0000, 16'hFFFF);  // seq 1
    put_item(OP_ACK, 16'h0010, 16'h0000);   // slot 0 but another sequence
    put_item(OP_ACK, 16'hFFFF, 16'h0000);   // empty slot
    put_item(OP_ACK, 16'h0001, 16'h0000);
    put_item(OP_ACK, 16'h0001, 16'h0000);   // duplicate ack
    put_item(OP_TICK, 16'h0000, 16'h0000);
    settle();
    write_timeout(16'd1);
    // fills slots 2..15, the last send hits busy slot 0
    for (int k = 0; k < 15; k++) put_item(OP_SEND, 16'($urandom), 16'hA000 + 16'(k));
    put_item(OP_TICK, 16'($urandom), 16'($urandom));

    foreach (phase_ticks[p]) begin
      // clear the table so each setting starts fresh
      settle();
      drain = live_seqs;
      foreach (drain[i]) put_item(OP_ACK, drain[i], 16'($urandom));
      settle();
      write_timeout(phase_ticks[p]);
      quiet  = (p == 2);
      done   = 0;
      paused = 1'b0;
      while (done < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          // run of sends, then one tick ages them all together
          burst = $urandom_range(4, 16);
          repeat (burst) put_item(OP_SEND, 16'($urandom), 16'($urandom));
          put_item(OP_TICK, 16'($urandom), 16'($urandom));
          done += burst + 1;
        end else if (r < 38) begin
          put_item(OP_SEND, 16'($urandom), 16'($urandom));
          done++;
        end else if (r < 66) begin
          if (live_seqs.size() > 0 && r < 58)
            ack = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
          else if (r < 62)
            ack = last_seq - 16'(16 * $urandom_range(1, 4));  // same slot, old sequence
          else
            ack = 16'($urandom);
          put_item(OP_ACK, ack, 16'($urandom));
          done++;
        end else if (r < 94) begin
          put_item(OP_TICK, 16'($urandom), 16'($urandom));
          done++;
        end else begin
          put_item(OP_UNUSED, 16'($urandom), 16'($urandom));
        end
        if (!paused && done >= PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end
    quiet = 1'b0;
    settle();

    $display("Run: %0d sends, %0d acks, %0d ticks, %0d unused codes over %0d timeout settings",
             op_count[OP_SEND], op_count[OP_ACK], op_count[OP_TICK], op_count[OP_UNUSED],
             settings_used);
    $display("Results: %0d sent, %0d acknowledged, %0d timed out, %0d refused",
             outcome_count[OUT_SENT], outcome_count[OUT_ACKED], outcome_count[OUT_TIMED_OUT],
             outcome_count[OUT_REFUSED]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("watchdog expired with %0d results outstanding", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
